FILE: design/punrank_pkg.sv
// shared types, widths and the factorial table for the permutation unranking block
`timescale 1ns / 1ps

package punrank_pkg;

    localparam int MAX_ELEMENTS = 12;
    localparam int RANK_W       = 29;
    localparam int ELEM_W       = 4;
    localparam int CNT_W        = 4;
    localparam int IDX_W        = $clog2(MAX_ELEMENTS);
    localparam int FACT_DEPTH   = MAX_ELEMENTS + 1;

    localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(10);

    // n! for n = 0 .. 12
    localparam logic [RANK_W-1:0] FACT_TABLE [FACT_DEPTH] = '{
        29'd1, 29'd1, 29'd2, 29'd6, 29'd24, 29'd120, 29'd720, 29'd5040,
        29'd40320, 29'd362880, 29'd3628800, 29'd39916800, 29'd479001600
    };

    // controller to datapath
    typedef struct packed {
        logic load;      // take a new rank, rebuild the element list
        logic sub;       // subtract one factorial, bump the digit
        logic emit;      // show one element, drop it from the list
        logic emit_err;  // show the single out-of-range result
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic rank_bad;  // incoming rank is zero or above count!
        logic rank_ge;   // remaining rank still holds another factorial
        logic at_last;   // current position is the final one
    } t_status;

endpackage

FILE: design/permutation_unrank_top.sv
// top level of the lexicographic permutation unranking block
`timescale 1ns / 1ps
// each request is loaded, then every digit is found by subtracting factorials and its element is emitted
// and registered; a new request is taken only after the last element, since the work is done by
//   the single subtract-and-compare unit that peels one factorial per cycle
// an out-of-range rank gives its one result the cycle after the request, busy stays low
// reset is synchronous, active low; element count comes back as ten, the receiver cannot stall

module permutation_unrank_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // request channel
    input  logic                            start,
    output logic                            busy,
    input  logic [punrank_pkg::RANK_W-1:0]  i_rank,
    // configuration write channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [punrank_pkg::CNT_W-1:0]   i_cfg_data,
    // result channel, one element per strobe
    output logic                            o_strobe,
    output logic [punrank_pkg::ELEM_W-1:0]  o_element,
    output logic [punrank_pkg::CNT_W-1:0]   o_position,
    output logic                            o_last,
    output logic                            o_rank_error
);
    import punrank_pkg::*;

    t_cmd    cmd;
    t_status status;
    logic    ctrl_busy;
    logic    cfg_we;

    // the count register only changes between requests
    assign o_cfg_ready = ~ctrl_busy;
    assign cfg_we      = i_cfg_valid & ~ctrl_busy;
    assign busy        = ctrl_busy;

    // sequencer: load, one subtract per cycle, then emit and shift the list
    punrank_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (ctrl_busy)
    );

    // rank, digit, element list and the registered result
    punrank_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_rank       (i_rank),
        .i_cmd        (cmd),
        .o_status     (status),
        .o_strobe     (o_strobe),
        .o_element    (o_element),
        .o_position   (o_position),
        .o_last       (o_last),
        .o_rank_error (o_rank_error)
    );

endmodule

FILE: design/punrank_ctrl.sv
// control state machine for the permutation unranking block
`timescale 1ns / 1ps

module punrank_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  punrank_pkg::t_status  i_status,
    output punrank_pkg::t_cmd     o_cmd,
    output logic                  o_busy
);
    import punrank_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_RUN
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_status.rank_bad) begin
                        o_cmd.emit_err = 1'b1;
                    end else begin
                        o_cmd.load = 1'b1;
                        n_state    = S_RUN;
                    end
                end
            end
            S_RUN: begin
                if (i_status.rank_ge) begin
                    o_cmd.sub = 1'b1;
                end else begin
                    o_cmd.emit = 1'b1;
                    if (i_status.at_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

FILE: design/punrank_dp.sv
// datapath: count register, remaining rank, digit counter, element list, result registers
`timescale 1ns / 1ps

module punrank_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [punrank_pkg::CNT_W-1:0]      i_cfg_data,
    input  logic [punrank_pkg::RANK_W-1:0]     i_rank,
    input  punrank_pkg::t_cmd                  i_cmd,
    output punrank_pkg::t_status               o_status,
    output logic                               o_strobe,
    output logic [punrank_pkg::ELEM_W-1:0]     o_element,
    output logic [punrank_pkg::CNT_W-1:0]      o_position,
    output logic                               o_last,
    output logic                               o_rank_error
);
    import punrank_pkg::*;

    logic [CNT_W-1:0]  r_element_count;
    logic [CNT_W-1:0]  eff_count;
    logic [RANK_W-1:0] r_rank;
    logic [CNT_W-1:0]  r_pos;
    logic [CNT_W-1:0]  r_last_pos;
    logic [IDX_W-1:0]  r_digit;
    logic [ELEM_W-1:0] r_list [MAX_ELEMENTS];
    logic [CNT_W-1:0]  rest;
    logic [RANK_W-1:0] fact_rest;

    logic              r_strobe;
    logic [ELEM_W-1:0] r_element;
    logic [CNT_W-1:0]  r_position;
    logic              r_last;
    logic              r_rank_error;

    // zero counts as one, anything above the maximum saturates
    always_comb begin
        priority if (r_element_count == '0) begin
            eff_count = CNT_W'(1);
        end else if (r_element_count > CNT_W'(MAX_ELEMENTS)) begin
            eff_count = CNT_W'(MAX_ELEMENTS);
        end else begin
            eff_count = r_element_count;
        end
    end

    assign rest      = r_last_pos - r_pos;
    assign fact_rest = FACT_TABLE[rest];

    assign o_status.rank_bad = (i_rank == '0) || (i_rank > FACT_TABLE[eff_count]);
    assign o_status.rank_ge  = (r_rank >= fact_rest);
    assign o_status.at_last  = (rest == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_element_count <= COUNT_RESET;
        end else if (i_cfg_we) begin
            r_element_count <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rank  <= '0;
            r_pos   <= '0;
            r_digit <= '0;
        end else if (i_cmd.load) begin
            r_rank     <= i_rank - RANK_W'(1);
            r_pos      <= '0;
            r_digit    <= '0;
            r_last_pos <= eff_count - CNT_W'(1);
            for (int i = 0; i < MAX_ELEMENTS; i++) begin
                r_list[i] <= ELEM_W'(i);
            end
        end else if (i_cmd.sub) begin
            r_rank  <= r_rank - fact_rest;
            r_digit <= r_digit + IDX_W'(1);
        end else if (i_cmd.emit) begin
            r_pos   <= r_pos + CNT_W'(1);
            r_digit <= '0;
            // close the gap left by the chosen element
            for (int i = 0; i < MAX_ELEMENTS - 1; i++) begin
                if (IDX_W'(i) >= r_digit) begin
                    r_list[i] <= r_list[i + 1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.emit | i_cmd.emit_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_err) begin
            r_element    <= '0;
            r_position   <= '0;
            r_last       <= 1'b1;
            r_rank_error <= 1'b1;
        end else if (i_cmd.emit) begin
            r_element    <= r_list[r_digit];
            r_position   <= r_pos;
            r_last       <= (rest == '0);
            r_rank_error <= 1'b0;
        end
    end

    assign o_strobe     = r_strobe;
    assign o_element    = r_element;
    assign o_position   = r_position;
    assign o_last       = r_last;
    assign o_rank_error = r_rank_error;

endmodule
